[hw/rtl/rrs_pkg.sv]
package rrs_pkg;

  // Jitter filter gain is 1/2^JITTER_SHIFT
  localparam int JITTER_SHIFT = 4;
  localparam logic [32:0] JITTER_HALF = 33'(1) << (JITTER_SHIFT - 1);

  // Event kinds
  localparam logic [2:0] OP_RTP    = 3'd0;
  localparam logic [2:0] OP_RTX    = 3'd1;
  localparam logic [2:0] OP_FEC    = 3'd2;
  localparam logic [2:0] OP_REPAIR = 3'd3;
  localparam logic [2:0] OP_REPORT = 3'd4;

  // Shared divider: dividend covers bytes*8000 of a 40-bit byte count
  localparam int DIV_DW    = 53;
  localparam int DIV_VW    = 48;
  localparam int DIV_CW    = $clog2(DIV_DW);
  localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(DIV_DW - 1);

  typedef struct packed {
    logic [2:0]  opcode;
    logic [30:0] seq_num;
    logic [15:0] payload_bytes;
    logic [47:0] send_time;
    logic [47:0] arrival_time;
  } in_item_t;

  typedef struct packed {
    logic [31:0] jitter_x16;
    logic [30:0] first_lost;
    logic [15:0] lost_count;
    logic        out_of_order;
    logic [8:0]  fraction_lost_q8;
    logic [15:0] fraction_received;
    logic [31:0] rate_kbps;
    logic [31:0] fec_rate_kbps;
    logic [31:0] total_received;
    logic [31:0] total_out_of_order;
    logic [31:0] total_retransmitted;
    logic [47:0] total_bytes;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_DW-1:0] quotient;
  } div_rsp_t;

endpackage

[hw/rtl/rrs_div.sv]
module rrs_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rrs_pkg::div_req_t req,
  output rrs_pkg::div_rsp_t rsp
);

  logic [rrs_pkg::DIV_DW-1:0] quo_r;
  logic [rrs_pkg::DIV_VW-1:0] rem_r;
  logic [rrs_pkg::DIV_VW-1:0] dvs_r;
  logic [rrs_pkg::DIV_CW-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [rrs_pkg::DIV_VW:0]   trial;
  logic [rrs_pkg::DIV_VW+1:0] sub;
  logic                       ge;

  // One restoring step: shift in the next dividend bit, try the subtract
  assign trial = {rem_r, quo_r[rrs_pkg::DIV_DW-1]};
  assign sub   = {1'b0, trial} - {2'b0, dvs_r};
  assign ge    = !sub[rrs_pkg::DIV_VW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        quo_r  <= req.dividend;
        dvs_r  <= req.divisor;
        rem_r  <= '0;
        cnt_r  <= rrs_pkg::DIV_LAST;
      end else if (busy_r) begin
        quo_r <= {quo_r[rrs_pkg::DIV_DW-2:0], ge};
        rem_r <= ge ? sub[rrs_pkg::DIV_VW-1:0] : trial[rrs_pkg::DIV_VW-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

[hw/rtl/rtp_receiver_statistics.sv]
// RTP receiver statistics. One event is taken at a time; in_stall stays high
// until its result is built. An accepted RTP or retransmitted packet passes
// through the staged jitter update (transit, difference, filter) before the
// next event can be taken; FEC, repair and unknown events skip that update.
// A report tick runs up to three divisions (fraction lost, data rate, FEC rate)
// through one shared bit-serial divider of 53 steps each. A finished result
// waits in the output register while the next event is already accepted.
module rtp_receiver_statistics (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rrs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rrs_pkg::out_item_t out_data
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DEC   = 4'd1;
  localparam logic [3:0] ST_PKT_T = 4'd2;
  localparam logic [3:0] ST_PKT_D = 4'd3;
  localparam logic [3:0] ST_PKT_J = 4'd4;
  localparam logic [3:0] ST_RPT_0 = 4'd5;
  localparam logic [3:0] ST_DIV_F = 4'd6;
  localparam logic [3:0] ST_DIV_R = 4'd7;
  localparam logic [3:0] ST_DIV_E = 4'd8;
  localparam logic [3:0] ST_RPT_E = 4'd9;
  localparam logic [3:0] ST_FIN   = 4'd10;

  logic [3:0]         state_r;
  rrs_pkg::in_item_t  item_r;
  logic               out_valid_r;
  rrs_pkg::out_item_t out_data_r;
  logic               started_r;

  // statistics state
  logic [48:0] prev_transit_r;
  logic [31:0] jitter_r;
  logic [30:0] highest_r;
  logic [30:0] base_seq_r;
  logic [15:0] frac_pkts_r;
  logic [15:0] frac_rep_r;
  logic [39:0] bytes_r;
  logic [39:0] fec_bytes_r;
  logic [47:0] last_rpt_r;
  logic [31:0] last_fec_rate_r;
  logic [31:0] cnt_rx_r;
  logic [31:0] cnt_ooo_r;
  logic [31:0] cnt_rtx_r;
  logic [31:0] cnt_rep_r;
  logic [47:0] cnt_bytes_r;

  // working registers
  logic [48:0] transit_r;
  logic [48:0] absd_r;
  logic [31:0] jdec_r;
  logic [47:0] dt_r;
  logic [30:0] exp_r;
  logic [30:0] lost_r;

  // result fields
  logic [30:0] first_lost_r;
  logic [15:0] lost_cnt_r;
  logic        ooo_r;
  logic [8:0]  frac_q8_r;
  logic [15:0] frac_rx_r;
  logic [31:0] rate_r;
  logic [31:0] fec_rate_r;

  rrs_pkg::div_req_t div_req;
  rrs_pkg::div_rsp_t div_rsp;

  logic [48:0] transit_nxt;
  logic [49:0] diff;
  logic [48:0] absd_nxt;
  logic [32:0] jround;
  logic [31:0] jdec_nxt;
  logic [49:0] jsum;
  logic [31:0] jitter_nxt;
  logic        seq_gt_hi;
  logic        seq_gt_base;
  logic        gap_over;
  logic [30:0] hi_plus1;
  logic [30:0] skipped;
  logic [15:0] pkts_inc;
  logic [15:0] rep_inc;
  logic [40:0] bytes_sum;
  logic [39:0] bytes_nxt;
  logic [40:0] fec_sum;
  logic [39:0] fec_nxt;
  logic [47:0] cnt_bytes_nxt;
  logic [47:0] dt_nxt;
  logic [31:0] exp_s;
  logic [16:0] got;
  logic [32:0] lost_s;
  logic        frac_ok;
  logic        div_skip;
  logic [31:0] q_sat;

  // jitter path, split over the transit, difference and filter stages
  assign transit_nxt = {1'b0, item_r.arrival_time} - {1'b0, item_r.send_time};
  assign diff        = {transit_r[48], transit_r} - {prev_transit_r[48], prev_transit_r};
  assign absd_nxt    = diff[49] ? 49'(-diff) : diff[48:0];
  assign jround      = {1'b0, jitter_r} + rrs_pkg::JITTER_HALF;
  assign jdec_nxt    = jitter_r - 32'(jround >> rrs_pkg::JITTER_SHIFT);
  assign jsum        = {18'b0, jdec_r} + {1'b0, absd_r};
  assign jitter_nxt  = (|jsum[49:32]) ? '1 : jsum[31:0];

  // sequence tracking
  assign seq_gt_hi   = item_r.seq_num > highest_r;
  assign seq_gt_base = item_r.seq_num > base_seq_r;
  assign gap_over    = {1'b0, item_r.seq_num} > ({1'b0, highest_r} + 32'd1);
  assign hi_plus1    = highest_r + 31'd1;
  assign skipped     = item_r.seq_num - hi_plus1;

  // saturating fraction counters, wrapping totals
  assign pkts_inc      = (frac_pkts_r == 16'hFFFF) ? frac_pkts_r : frac_pkts_r + 16'd1;
  assign rep_inc       = (frac_rep_r == 16'hFFFF) ? frac_rep_r : frac_rep_r + 16'd1;
  assign bytes_sum     = {1'b0, bytes_r} + {25'b0, item_r.payload_bytes};
  assign bytes_nxt     = bytes_sum[40] ? '1 : bytes_sum[39:0];
  assign fec_sum       = {1'b0, fec_bytes_r} + {25'b0, item_r.payload_bytes};
  assign fec_nxt       = fec_sum[40] ? '1 : fec_sum[39:0];
  assign cnt_bytes_nxt = cnt_bytes_r + {32'b0, item_r.payload_bytes};

  // report setup
  assign dt_nxt  = (item_r.arrival_time > last_rpt_r) ? item_r.arrival_time - last_rpt_r : '0;
  assign exp_s   = {1'b0, highest_r} - {1'b0, base_seq_r};
  assign got     = {1'b0, frac_pkts_r} + {1'b0, frac_rep_r};
  assign lost_s  = {exp_s[31], exp_s} - {16'b0, got};
  assign frac_ok = !exp_s[31] && (exp_s != '0) && !lost_s[32] && (lost_s != '0);

  // shared divider operands
  assign div_skip = (state_r == ST_DIV_R || state_r == ST_DIV_E) && (dt_r == '0);
  always_comb begin
    div_req.start    = (state_r == ST_DIV_F || state_r == ST_DIV_R || state_r == ST_DIV_E)
                       && !started_r && !div_skip;
    div_req.dividend = '0;
    div_req.divisor  = dt_r;
    case (state_r)
      ST_DIV_F: begin
        div_req.dividend = {14'b0, lost_r, 8'b0};
        div_req.divisor  = {17'b0, exp_r};
      end
      ST_DIV_R: div_req.dividend = {bytes_r, 13'b0} - {6'b0, bytes_r, 7'b0}
                                   - {7'b0, bytes_r, 6'b0};
      ST_DIV_E: div_req.dividend = {fec_bytes_r, 13'b0} - {6'b0, fec_bytes_r, 7'b0}
                                   - {7'b0, fec_bytes_r, 6'b0};
      default: div_req.dividend = '0;
    endcase
  end
  assign q_sat = (|div_rsp.quotient[rrs_pkg::DIV_DW-1:32]) ? '1 : div_rsp.quotient[31:0];

  rrs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      out_valid_r     <= 1'b0;
      started_r       <= 1'b0;
      prev_transit_r  <= '0;
      jitter_r        <= '0;
      highest_r       <= '0;
      base_seq_r      <= '0;
      frac_pkts_r     <= '0;
      frac_rep_r      <= '0;
      bytes_r         <= '0;
      fec_bytes_r     <= '0;
      last_rpt_r      <= '0;
      last_fec_rate_r <= '0;
      cnt_rx_r        <= '0;
      cnt_ooo_r       <= '0;
      cnt_rtx_r       <= '0;
      cnt_rep_r       <= '0;
      cnt_bytes_r     <= '0;
    end else begin
      // drop the taken result unless a new one is loaded below
      if (out_valid_r && !out_stall && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            item_r  <= in_data;
            state_r <= ST_DEC;
          end
        end
        ST_DEC: begin
          first_lost_r <= '0;
          lost_cnt_r   <= '0;
          ooo_r        <= 1'b0;
          frac_q8_r    <= '0;
          frac_rx_r    <= '0;
          rate_r       <= '0;
          fec_rate_r   <= '0;
          case (item_r.opcode)
            rrs_pkg::OP_RTP, rrs_pkg::OP_RTX: state_r <= ST_PKT_T;
            rrs_pkg::OP_FEC: begin
              cnt_bytes_r <= cnt_bytes_nxt;
              fec_bytes_r <= fec_nxt;
              state_r     <= ST_FIN;
            end
            rrs_pkg::OP_REPAIR: begin
              frac_rep_r <= rep_inc;
              cnt_rep_r  <= cnt_rep_r + 32'd1;
              if (seq_gt_hi) begin
                highest_r <= item_r.seq_num;
              end
              state_r <= ST_FIN;
            end
            rrs_pkg::OP_REPORT: state_r <= ST_RPT_0;
            default: state_r <= ST_FIN;
          endcase
        end
        ST_PKT_T: begin
          transit_r <= transit_nxt;
          state_r   <= ST_PKT_D;
        end
        ST_PKT_D: begin
          absd_r  <= absd_nxt;
          jdec_r  <= jdec_nxt;
          state_r <= ST_PKT_J;
        end
        ST_PKT_J: begin
          jitter_r       <= jitter_nxt;
          prev_transit_r <= transit_r;
          cnt_rx_r       <= cnt_rx_r + 32'd1;
          cnt_bytes_r    <= cnt_bytes_nxt;
          if (seq_gt_hi) begin
            highest_r <= item_r.seq_num;
          end
          if (item_r.opcode == rrs_pkg::OP_RTP) begin
            frac_pkts_r <= pkts_inc;
            bytes_r     <= bytes_nxt;
            if (gap_over) begin
              first_lost_r <= hi_plus1;
              lost_cnt_r   <= (|skipped[30:16]) ? 16'hFFFF : skipped[15:0];
            end else if (!seq_gt_hi) begin
              ooo_r     <= 1'b1;
              cnt_ooo_r <= cnt_ooo_r + 32'd1;
            end
          end else begin
            cnt_rtx_r <= cnt_rtx_r + 32'd1;
            if (seq_gt_base) begin
              frac_pkts_r <= pkts_inc;
              bytes_r     <= bytes_nxt;
            end
          end
          state_r <= ST_FIN;
        end
        ST_RPT_0: begin
          dt_r   <= dt_nxt;
          exp_r  <= exp_s[30:0];
          lost_r <= lost_s[30:0];
          if (frac_pkts_r == '0) begin
            frac_q8_r  <= 9'd256;
            fec_rate_r <= last_fec_rate_r;
            state_r    <= ST_RPT_E;
          end else begin
            frac_rx_r  <= frac_pkts_r;
            base_seq_r <= highest_r;
            state_r    <= frac_ok ? ST_DIV_F : ST_DIV_R;
          end
        end
        ST_DIV_F, ST_DIV_R, ST_DIV_E: begin
          if (!started_r) begin
            if (div_skip) begin
              if (state_r == ST_DIV_E) begin
                last_fec_rate_r <= '0;
                state_r         <= ST_RPT_E;
              end else begin
                state_r <= ST_DIV_E;
              end
            end else begin
              started_r <= 1'b1;
            end
          end else if (div_rsp.done) begin
            started_r <= 1'b0;
            case (state_r)
              ST_DIV_F: begin
                frac_q8_r <= div_rsp.quotient[8:0];
                state_r   <= ST_DIV_R;
              end
              ST_DIV_R: begin
                rate_r  <= q_sat;
                state_r <= ST_DIV_E;
              end
              default: begin
                fec_rate_r      <= q_sat;
                last_fec_rate_r <= q_sat;
                state_r         <= ST_RPT_E;
              end
            endcase
          end
        end
        ST_RPT_E: begin
          if (div_skip) begin
            fec_rate_r <= '0;
          end
          frac_pkts_r <= '0;
          frac_rep_r  <= '0;
          bytes_r     <= '0;
          fec_bytes_r <= '0;
          last_rpt_r  <= item_r.arrival_time;
          state_r     <= ST_FIN;
        end
        ST_FIN: begin
          // hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_valid_r                    <= 1'b1;
            out_data_r.jitter_x16          <= jitter_r;
            out_data_r.first_lost          <= first_lost_r;
            out_data_r.lost_count          <= lost_cnt_r;
            out_data_r.out_of_order        <= ooo_r;
            out_data_r.fraction_lost_q8    <= frac_q8_r;
            out_data_r.fraction_received   <= frac_rx_r;
            out_data_r.rate_kbps           <= rate_r;
            out_data_r.fec_rate_kbps       <= fec_rate_r;
            out_data_r.total_received      <= cnt_rx_r;
            out_data_r.total_out_of_order  <= cnt_ooo_r;
            out_data_r.total_retransmitted <= cnt_rtx_r;
            out_data_r.total_bytes         <= cnt_bytes_r;
            state_r                        <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // divider is only launched while idle
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // divider completion only lands in a division state
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV_F || state_r == ST_DIV_R || state_r == ST_DIV_E))
    else $error("divider result with no division pending");

  // an accepted item is decoded next
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_DEC))
    else $error("accepted item not decoded");

  // fraction lost stays within Q8 range
  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.fraction_lost_q8 <= 9'd256))
    else $error("fraction lost out of range");

endmodule
